// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, codes and helpers for the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   // default number of fraction bits (Q24.8)
   localparam int unsigned FRAC_BITS_DEFAULT = 8;

   // saturation extremes of the raw 32-bit value
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // largest magnitudes that still fit, per sign
   localparam logic [63:0] MAG_POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] MAG_NEG_LIMIT = 64'h0000_0000_8000_0000;

   // operation codes
   typedef enum logic [3:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_GT       = 4'd4,
      ACT_LT       = 4'd5,
      ACT_GE       = 4'd6,
      ACT_LE       = 4'd7,
      ACT_EQ       = 4'd8,
      ACT_NE       = 4'd9,
      ACT_INC      = 4'd10,
      ACT_DEC      = 4'd11,
      ACT_MIN      = 4'd12,
      ACT_MAX      = 4'd13,
      ACT_FROM_INT = 4'd14,
      ACT_TO_INT   = 4'd15
   } action_type;

   // one result beat
   typedef struct packed {
      logic signed [31:0] result_value;
      logic               compare_true;
      logic               overflow;
      logic               divide_by_zero;
   } result_type;

   // apply a sign to an unsigned magnitude and clamp to 32 bits
   function automatic result_type sat_magnitude(input logic [63:0] mag, input logic neg);
      result_type r;
      r = '0;
      if (neg) begin
         if (mag > MAG_NEG_LIMIT) begin
            r.result_value = S32_MIN;
            r.overflow     = 1'b1;
         end else begin
            r.result_value = $signed(~mag[31:0] + 32'd1);
         end
      end else begin
         if (mag > MAG_POS_LIMIT) begin
            r.result_value = S32_MAX;
            r.overflow     = 1'b1;
         end else begin
            r.result_value = $signed(mag[31:0]);
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/fpa_req_if.sv
// ----------------------------------------------------------------------------
// fpa_req_if
// Operation channel: valid/ready handshake with action and two operands.
// ----------------------------------------------------------------------------
interface fpa_req_if;

   logic               valid;
   logic               ready;
   fpa_pkg::action_type action;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, output action, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input action, input operand_a, input operand_b,
                   output ready);

endinterface

// File: rtl/fpa_rsp_if.sv
// ----------------------------------------------------------------------------
// fpa_rsp_if
// Result channel: valid/ready handshake with the result value and flags.
// ----------------------------------------------------------------------------
interface fpa_rsp_if;

   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic               compare_true;
   logic               overflow;
   logic               divide_by_zero;

   modport source (output valid, output result_value, output compare_true,
                   output overflow, output divide_by_zero, input ready);
   modport sink   (input valid, input result_value, input compare_true,
                   input overflow, input divide_by_zero, output ready);

endinterface

// File: rtl/fpa_delay.sv
// ----------------------------------------------------------------------------
// fpa_delay
// Stall-aware shift line that keeps side data aligned with the long path.
// ----------------------------------------------------------------------------
module fpa_delay #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift one place per advancing cycle
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= in_data;
         for (int unsigned k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign out_data = tap_ff[DEPTH-1];

endmodule

// File: rtl/fpa_basic.sv
// ----------------------------------------------------------------------------
// fpa_basic
// Single-stage unit for add, sub, compares, inc/dec, min/max and conversions.
// ----------------------------------------------------------------------------
module fpa_basic #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                en,
   input  fpa_pkg::action_type action,
   input  logic signed [31:0]  operand_a,
   input  logic signed [31:0]  operand_b,
   output fpa_pkg::result_type result
);

   localparam logic [32:0] TRUNC_BIAS = (33'd1 << FRAC_BITS) - 33'd1;

   fpa_pkg::result_type result_ff;
   fpa_pkg::result_type result_in;

   logic signed [32:0] sum;
   logic signed [32:0] diff;
   logic signed [32:0] incr;
   logic signed [32:0] decr;
   logic signed [32:0] trunc_sum;
   logic signed [32:0] trunc_shift;
   logic               a_gt;
   logic               a_lt;
   logic               a_eq;
   logic               int_fits;

   // clamp a 33-bit signed value into 32 bits
   function automatic fpa_pkg::result_type sat_wide(input logic signed [32:0] v);
      fpa_pkg::result_type r;
      r = '0;
      if (v[32] != v[31]) begin
         r.result_value = v[32] ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
         r.overflow     = 1'b1;
      end else begin
         r.result_value = v[31:0];
      end
      return r;
   endfunction

   // parallel adders and comparators
   always_comb begin
      sum         = $signed({operand_a[31], operand_a}) + $signed({operand_b[31], operand_b});
      diff        = $signed({operand_a[31], operand_a}) - $signed({operand_b[31], operand_b});
      incr        = $signed({operand_a[31], operand_a}) + 33'sd1;
      decr        = $signed({operand_a[31], operand_a}) - 33'sd1;
      trunc_sum   = $signed({operand_a[31], operand_a})
                    + $signed(operand_a[31] ? TRUNC_BIAS : 33'd0);
      trunc_shift = trunc_sum >>> FRAC_BITS;
      a_gt        = operand_a > operand_b;
      a_lt        = operand_a < operand_b;
      a_eq        = operand_a == operand_b;
      int_fits    = (&operand_a[31:31-FRAC_BITS]) | ~(|operand_a[31:31-FRAC_BITS]);
   end

   // result selection
   always_comb begin
      result_in = '0;
      case (action)
         fpa_pkg::ACT_ADD: result_in = sat_wide(sum);
         fpa_pkg::ACT_SUB: result_in = sat_wide(diff);
         fpa_pkg::ACT_GT:  result_in.compare_true = a_gt;
         fpa_pkg::ACT_LT:  result_in.compare_true = a_lt;
         fpa_pkg::ACT_GE:  result_in.compare_true = ~a_lt;
         fpa_pkg::ACT_LE:  result_in.compare_true = ~a_gt;
         fpa_pkg::ACT_EQ:  result_in.compare_true = a_eq;
         fpa_pkg::ACT_NE:  result_in.compare_true = ~a_eq;
         fpa_pkg::ACT_INC: result_in = sat_wide(incr);
         fpa_pkg::ACT_DEC: result_in = sat_wide(decr);
         fpa_pkg::ACT_MIN: result_in.result_value = a_lt ? operand_a : operand_b;
         fpa_pkg::ACT_MAX: result_in.result_value = a_gt ? operand_a : operand_b;
         fpa_pkg::ACT_FROM_INT: begin
            if (int_fits) begin
               result_in.result_value = {operand_a[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            end else begin
               result_in.result_value = operand_a[31] ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
               result_in.overflow     = 1'b1;
            end
         end
         fpa_pkg::ACT_TO_INT: result_in.result_value = trunc_shift[31:0];
         default: result_in = '0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: rtl/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// Three-stage multiplier: product, magnitude, round half away and saturate.
// ----------------------------------------------------------------------------
module fpa_mul #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [31:0]  operand_a,
   input  logic signed [31:0]  operand_b,
   output fpa_pkg::result_type result
);

   localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);

   logic signed [63:0]  prod_ff;
   logic signed [63:0]  prod_in;
   logic [63:0]         mag_ff;
   logic [63:0]         mag_in;
   logic                neg_ff;
   logic [63:0]         rounded;
   fpa_pkg::result_type result_ff;
   fpa_pkg::result_type result_in;

   // stage math
   always_comb begin
      prod_in   = $signed(operand_a) * $signed(operand_b);
      mag_in    = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      rounded   = (mag_ff + ROUND_HALF) >> FRAC_BITS;
      result_in = fpa_pkg::sat_magnitude(rounded, neg_ff);
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         mag_ff    <= mag_in;
         neg_ff    <= prod_ff[63];
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, with rounding.
// ----------------------------------------------------------------------------
module fpa_div #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [31:0]  operand_a,
   input  logic signed [31:0]  operand_b,
   output fpa_pkg::result_type result
);

   // dividend is |a| scaled by 2^(FRAC_BITS+1): one extra bit for rounding
   localparam int unsigned QW = 33 + FRAC_BITS;

   typedef struct packed {
      logic [31:0]   rem;
      logic [QW-1:0] dq;
      logic [31:0]   den;
      logic          neg;
      logic          a_neg;
      logic          dz;
   } step_type;

   step_type            step_ff [QW+1];
   step_type            prep_in;
   logic [QW-1:0]       quot_ff;
   logic [QW-1:0]       quot_in;
   logic                neg_ff;
   logic                a_neg_ff;
   logic                dz_ff;
   fpa_pkg::result_type result_ff;
   fpa_pkg::result_type result_in;

   // operand magnitudes and signs
   always_comb begin
      prep_in       = '0;
      prep_in.dq    = {(operand_a[31] ? 32'(-operand_a) : 32'(operand_a)),
                       {(FRAC_BITS+1){1'b0}}};
      prep_in.den   = operand_b[31] ? 32'(-operand_b) : 32'(operand_b);
      prep_in.neg   = operand_a[31] ^ operand_b[31];
      prep_in.a_neg = operand_a[31];
      prep_in.dz    = (operand_b == 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff[0] <= prep_in;
      end
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [32:0] trial;
      logic        fits;
      step_type    step_in;

      always_comb begin
         trial         = {step_ff[k-1].rem, step_ff[k-1].dq[QW-1]};
         fits          = trial >= {1'b0, step_ff[k-1].den};
         step_in       = step_ff[k-1];
         step_in.rem   = fits ? 32'(trial - {1'b0, step_ff[k-1].den}) : trial[31:0];
         step_in.dq    = {step_ff[k-1].dq[QW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            step_ff[k] <= step_in;
         end
      end
   end

   // round half away: halve the doubled quotient after adding one
   assign quot_in = (step_ff[QW].dq + QW'(1)) >> 1;

   // saturation and divide-by-zero handling
   always_comb begin
      if (dz_ff) begin
         result_in                = '0;
         result_in.result_value   = a_neg_ff ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
         result_in.overflow       = 1'b1;
         result_in.divide_by_zero = 1'b1;
      end else begin
         result_in = fpa_pkg::sat_magnitude(64'(quot_ff), neg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff   <= quot_in;
         neg_ff    <= step_ff[QW].neg;
         a_neg_ff  <= step_ff[QW].a_neg;
         dz_ff     <= step_ff[QW].dz;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: rtl/fixed_point_q24_8_alu_top.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// Signed fixed-point ALU (Q24.8 by default) with a fully pipelined datapath.
// ----------------------------------------------------------------------------
// usage
//   req_if carries one operation per beat: action, operand_a, operand_b.
//   rsp_if returns one result beat per operation, in order: result_value,
//   compare_true, overflow, divide_by_zero.
//   throughput: one operation per cycle while req_if.ready is high, any
//   mix of actions. The path length is set by the divider, which
//   resolves one quotient bit per stage over FRAC_BITS + 33 stages.
//   Every action takes the same path length so results stay in order.
//   stall: an output register plus one skid register sit behind the
//   pipeline; the pipeline keeps accepting while a result waits, and
//   req_if.ready drops only once the skid register is occupied. Nothing is
//   dropped or repeated.
//   reset: synchronous, active high; clears all valid bits, no result is
//   pending afterward. There is no configuration and no other state.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   fpa_req_if.sink         req_if,
   fpa_rsp_if.source       rsp_if
);

   localparam int unsigned QW   = 33 + FRAC_BITS;
   localparam int unsigned LAST = QW + 3;
   localparam int unsigned RW   = $bits(fpa_pkg::result_type);

   logic                en;
   logic [LAST:0]       valid_ff;
   logic [LAST:0]       valid_in;
   fpa_pkg::action_type action_ff;
   logic signed [31:0]  operand_a_ff;
   logic signed [31:0]  operand_b_ff;

   fpa_pkg::result_type basic_res;
   fpa_pkg::result_type mul_res;
   fpa_pkg::result_type div_res;
   logic [RW-1:0]       basic_dly;
   logic [RW-1:0]       mul_dly;
   logic [3:0]          action_dly;
   fpa_pkg::result_type last_res;

   logic                out_valid_ff;
   logic                out_valid_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   fpa_pkg::result_type out_ff;
   fpa_pkg::result_type out_in;
   fpa_pkg::result_type skid_ff;
   fpa_pkg::result_type skid_in;
   logic                out_take;

   // pipeline advances whenever the skid register is free
   assign en           = ~skid_valid_ff;
   assign req_if.ready = en;

   // valid bits travel with the data
   assign valid_in = {valid_ff[LAST-1:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (en) begin
         action_ff    <= req_if.action;
         operand_a_ff <= req_if.operand_a;
         operand_b_ff <= req_if.operand_b;
      end
   end

   // execution units
   fpa_basic #(.FRAC_BITS(FRAC_BITS)) u_basic (
      .clock     (clock),
      .en        (en),
      .action    (action_ff),
      .operand_a (operand_a_ff),
      .operand_b (operand_b_ff),
      .result    (basic_res)
   );

   fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock     (clock),
      .en        (en),
      .operand_a (operand_a_ff),
      .operand_b (operand_b_ff),
      .result    (mul_res)
   );

   fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .en        (en),
      .operand_a (operand_a_ff),
      .operand_b (operand_b_ff),
      .result    (div_res)
   );

   // align short paths with the divider
   fpa_delay #(.WIDTH(RW), .DEPTH(QW + 2)) u_basic_dly (
      .clock    (clock),
      .en       (en),
      .in_data  (basic_res),
      .out_data (basic_dly)
   );

   fpa_delay #(.WIDTH(RW), .DEPTH(QW)) u_mul_dly (
      .clock    (clock),
      .en       (en),
      .in_data  (mul_res),
      .out_data (mul_dly)
   );

   fpa_delay #(.WIDTH(4), .DEPTH(LAST)) u_action_dly (
      .clock    (clock),
      .en       (en),
      .in_data  (action_ff),
      .out_data (action_dly)
   );

   // pick the unit that owns this action
   always_comb begin
      case (fpa_pkg::action_type'(action_dly))
         fpa_pkg::ACT_MUL: last_res = mul_dly;
         fpa_pkg::ACT_DIV: last_res = div_res;
         default:          last_res = basic_dly;
      endcase
   end

   // output register and skid register
   always_comb begin
      out_take      = out_valid_ff & rsp_if.ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (~out_valid_ff | out_take) begin
         out_valid_in = valid_ff[LAST];
         out_in       = last_res;
      end else if (valid_ff[LAST]) begin
         skid_valid_in = 1'b1;
         skid_in       = last_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // result beat
   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.result_value   = out_ff.result_value;
   assign rsp_if.compare_true   = out_ff.compare_true;
   assign rsp_if.overflow       = out_ff.overflow;
   assign rsp_if.divide_by_zero = out_ff.divide_by_zero;

endmodule

// File: test/fixed_point_q24_8_alu_check.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_check
// Watches both channels of the fixed-point ALU. Every accepted operation beat
// is run through an exact integer model of the ALU and queued. Every
// accepted result beat is compared field by field with the oldest queued
// result. Failure, pending and coverage counts go back to the testbench top.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_check #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   fpa_req_if   req_mon,
   fpa_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked_count,
   output int   saturated_count,
   output int   zero_div_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // one queued expectation, with the operation kept for messages
   typedef struct {
      fpa_pkg::action_type op;
      logic signed [31:0]  a;
      logic signed [31:0]  b;
      fpa_pkg::result_type want;
   } expectation_type;

   expectation_type expected_results[$];

   // clamp a wide value to the signed 32-bit range, flag when clamped
   function automatic fpa_pkg::result_type clamp_to_s32(input longint v);
      fpa_pkg::result_type r;
      r = '0;
      if (v > longint'(fpa_pkg::S32_MAX)) begin
         r.result_value = fpa_pkg::S32_MAX;
         r.overflow     = 1'b1;
      end else if (v < longint'(fpa_pkg::S32_MIN)) begin
         r.result_value = fpa_pkg::S32_MIN;
         r.overflow     = 1'b1;
      end else begin
         r.result_value = v[31:0];
      end
      return r;
   endfunction

   // exact integer model of one alu operation
   function automatic fpa_pkg::result_type alu_result(input fpa_pkg::action_type op,
                                                      input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
      fpa_pkg::result_type r;
      longint      sa;
      longint      sb;
      longint      wide;
      logic [63:0] mag;
      logic [63:0] num;
      logic [63:0] den;
      logic        neg;
      sa = a;
      sb = b;
      r  = '0;
      case (op)
         fpa_pkg::ACT_ADD: r = clamp_to_s32(sa + sb);
         fpa_pkg::ACT_SUB: r = clamp_to_s32(sa - sb);
         fpa_pkg::ACT_MUL: begin
            // round the magnitude, halves away from zero
            wide = sa * sb;
            neg  = wide < 0;
            mag  = neg ? -wide : wide;
            mag  = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            r    = clamp_to_s32(neg ? -longint'(mag) : longint'(mag));
         end
         fpa_pkg::ACT_DIV: begin
            if (sb == 0) begin
               r.result_value   = (sa < 0) ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
               r.overflow       = 1'b1;
               r.divide_by_zero = 1'b1;
            end else begin
               // rounded quotient of magnitudes, halves away from zero
               num = (sa < 0 ? -sa : sa);
               num = num << FRAC_BITS;
               den = (sb < 0 ? -sb : sb);
               mag = (2 * num + den) / (2 * den);
               neg = (sa < 0) != (sb < 0);
               r   = clamp_to_s32(neg ? -longint'(mag) : longint'(mag));
            end
         end
         fpa_pkg::ACT_GT:       r.compare_true = sa > sb;
         fpa_pkg::ACT_LT:       r.compare_true = sa < sb;
         fpa_pkg::ACT_GE:       r.compare_true = sa >= sb;
         fpa_pkg::ACT_LE:       r.compare_true = sa <= sb;
         fpa_pkg::ACT_EQ:       r.compare_true = sa == sb;
         fpa_pkg::ACT_NE:       r.compare_true = sa != sb;
         fpa_pkg::ACT_INC:      r = clamp_to_s32(sa + 1);
         fpa_pkg::ACT_DEC:      r = clamp_to_s32(sa - 1);
         fpa_pkg::ACT_MIN:      r.result_value = (sa < sb) ? a : b;
         fpa_pkg::ACT_MAX:      r.result_value = (sa > sb) ? a : b;
         fpa_pkg::ACT_FROM_INT: r = clamp_to_s32(sa * (longint'(1) << FRAC_BITS));
         default: begin
            // to_int: division truncates toward zero
            wide           = sa / (longint'(1) << FRAC_BITS);
            r.result_value = wide[31:0];
         end
      endcase
      return r;
   endfunction

   task automatic report_field(input expectation_type e, input string field,
                               input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s mismatch for %s a=%h b=%h: expected %h, actual %h",
               $time, field, e.op.name(), e.a, e.b, want, got);
      fail_count++;
   endtask

   // predict on operation beats, compare on result beats
   always @(posedge clock) begin
      expectation_type e;
      if (reset) begin
         expected_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            e.op   = req_mon.action;
            e.a    = req_mon.operand_a;
            e.b    = req_mon.operand_b;
            e.want = alu_result(req_mon.action, req_mon.operand_a, req_mon.operand_b);
            expected_results.push_back(e);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, actual %h",
                        $time, rsp_mon.result_value);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (e.want.result_value !== rsp_mon.result_value)
                  report_field(e, "result_value", e.want.result_value,
                               rsp_mon.result_value);
               if (e.want.compare_true !== rsp_mon.compare_true)
                  report_field(e, "compare_true", e.want.compare_true,
                               rsp_mon.compare_true);
               if (e.want.overflow !== rsp_mon.overflow)
                  report_field(e, "overflow", e.want.overflow, rsp_mon.overflow);
               if (e.want.divide_by_zero !== rsp_mon.divide_by_zero)
                  report_field(e, "divide_by_zero", e.want.divide_by_zero,
                               rsp_mon.divide_by_zero);
               checked_count++;
               if (e.want.overflow)
                  saturated_count++;
               if (e.want.divide_by_zero)
                  zero_div_count++;
            end
         end
      end
      pending <= expected_results.size();
   end

endmodule

// File: test/fixed_point_q24_8_alu_top_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top_tb
// Drives the fixed-point ALU with a directed set of edge cases, then random
// operations under four idling mixes on both channels. Checking is done by
// the check module beside the block; this top makes stimulus and decides.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAC_BITS    = fpa_pkg::FRAC_BITS_DEFAULT;
   localparam int          LATENCY      = FRAC_BITS + 37;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          RANDOM_ITEMS = 1950;

   logic clock;
   logic reset;

   fpa_req_if req_if ();
   fpa_rsp_if rsp_if ();

   int fail_count;
   int pending;
   int checked_count;
   int saturated_count;
   int zero_div_count;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int ops_sent      = 0;
   int directed_ops  = 0;
   int idle_cycles   = 0;

   fixed_point_q24_8_alu_top #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   fixed_point_q24_8_alu_check #(.FRAC_BITS(FRAC_BITS)) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked_count   (checked_count),
      .saturated_count (saturated_count),
      .zero_div_count  (zero_div_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side backpressure
   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // send one operation beat, with random idle cycles ahead of it
   task automatic issue_op(input fpa_pkg::action_type op, input logic signed [31:0] a,
                           input logic signed [31:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid     <= 1'b0;
         req_if.action    <= fpa_pkg::action_type'($urandom_range(0, 15));
         req_if.operand_a <= $urandom;
         req_if.operand_b <= $urandom;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.action    <= op;
      req_if.operand_a <= a;
      req_if.operand_b <= b;
      do @(posedge clock); while (!req_if.ready);
      ops_sent++;
   endtask

   // stop sending until every result is back, then let the pipe settle
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // operand mix: full range, small, extremes, near saturation points
   function automatic logic signed [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom;
         3:       v = $urandom_range(0, 2047) - 1024;
         4:       v = $urandom >> $urandom_range(0, 31);
         5: begin
            case ($urandom_range(0, 4))
               0:       v = fpa_pkg::S32_MAX;
               1:       v = fpa_pkg::S32_MIN;
               2:       v = 32'd0;
               3:       v = 32'd1;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         6:       v = $urandom_range(0, 4095) << FRAC_BITS;
         7:       v = fpa_pkg::S32_MAX - $urandom_range(0, 300);
         8:       v = (32'd1 << (31 - FRAC_BITS)) + $urandom_range(0, 4) - 2;
         default: v = $urandom & 32'h0000_FFFF;
      endcase
      if ($urandom_range(0, 1) && v != fpa_pkg::S32_MIN)
         v = -v;
      return v;
   endfunction

   task automatic random_phase(input int idle_pct, input int stall, input int count);
      logic signed [31:0] a;
      logic signed [31:0] b;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      repeat (count) begin
         a = pick_operand();
         b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
         issue_op(fpa_pkg::action_type'($urandom_range(0, 15)), a, b);
      end
      drain_results();
   endtask

   // stimulus
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.action    = fpa_pkg::ACT_ADD;
      req_if.operand_a = '0;
      req_if.operand_b = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed edge cases, full throughput
      issue_op(fpa_pkg::ACT_ADD, fpa_pkg::S32_MAX, 32'sd1);
      issue_op(fpa_pkg::ACT_ADD, fpa_pkg::S32_MIN, -32'sd1);
      issue_op(fpa_pkg::ACT_SUB, fpa_pkg::S32_MIN, 32'sd1);
      issue_op(fpa_pkg::ACT_SUB, 32'sd0, fpa_pkg::S32_MIN);
      issue_op(fpa_pkg::ACT_MUL, fpa_pkg::S32_MIN, fpa_pkg::S32_MIN);
      issue_op(fpa_pkg::ACT_MUL, 32'sd1, 32'sd128);
      issue_op(fpa_pkg::ACT_MUL, -32'sd1, 32'sd128);
      issue_op(fpa_pkg::ACT_DIV, 32'sd5, 32'sd0);
      issue_op(fpa_pkg::ACT_DIV, -32'sd5, 32'sd0);
      issue_op(fpa_pkg::ACT_DIV, 32'sd0, 32'sd0);
      issue_op(fpa_pkg::ACT_DIV, fpa_pkg::S32_MIN, -32'sd1);
      issue_op(fpa_pkg::ACT_DIV, 32'sd256, 32'sd768);
      issue_op(fpa_pkg::ACT_DIV, -32'sd1, 32'sd512);
      issue_op(fpa_pkg::ACT_GT, 32'sd5, 32'sd5);
      issue_op(fpa_pkg::ACT_LT, fpa_pkg::S32_MIN, fpa_pkg::S32_MAX);
      issue_op(fpa_pkg::ACT_GE, 32'sd5, 32'sd5);
      issue_op(fpa_pkg::ACT_LE, fpa_pkg::S32_MAX, fpa_pkg::S32_MIN);
      issue_op(fpa_pkg::ACT_EQ, -32'sd1, -32'sd1);
      issue_op(fpa_pkg::ACT_NE, 32'sd0, 32'sd0);
      issue_op(fpa_pkg::ACT_INC, fpa_pkg::S32_MAX, 32'sd0);
      issue_op(fpa_pkg::ACT_DEC, fpa_pkg::S32_MIN, 32'sd0);
      issue_op(fpa_pkg::ACT_MIN, 32'sd7, 32'sd7);
      issue_op(fpa_pkg::ACT_MAX, fpa_pkg::S32_MIN, fpa_pkg::S32_MAX);
      issue_op(fpa_pkg::ACT_FROM_INT, 32'sd1 << (31 - FRAC_BITS), 32'sd0);
      issue_op(fpa_pkg::ACT_FROM_INT, -(32'sd1 << (31 - FRAC_BITS)), 32'sd0);
      issue_op(fpa_pkg::ACT_TO_INT, -32'sd257, 32'sd0);
      directed_ops = ops_sent;
      drain_results();

      // random operations under each idling mix
      random_phase(0, 0, RANDOM_ITEMS / 4);
      random_phase(82, 0, RANDOM_ITEMS / 4);
      random_phase(0, 82, RANDOM_ITEMS / 4);
      random_phase(19, 19, RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4));

      $display("run covered %0d operations (%0d directed) in four idling mixes",
               ops_sent, directed_ops);
      $display("%0d results checked, %0d saturated, %0d divisions by zero",
               checked_count, saturated_count, zero_div_count);
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
